// File: rtl/mwsc_pkg.sv
`timescale 1ns / 1ps

package mwsc_pkg;

   // Fixed field widths of the result and configuration channels
   localparam int SUM_W      = 32;
   localparam int HIT_W      = 9;
   localparam int WSIZE_W    = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_SIZE     = 3'd0,
      CSR_TUMBLING_MODE   = 3'd1,
      CSR_ABSOLUTE_VALUE  = 3'd2,
      CSR_COUNT_NONLOSING = 3'd3,
      CSR_SECOND_ENABLE   = 3'd4,
      CSR_SUM_THRESHOLD   = 3'd5
   } csr_index_type;

   localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = 9'd1;

endpackage

// File: rtl/mwsc_if.sv
`timescale 1ns / 1ps

interface mwsc_req_if #(
   parameter int VALUE_BITS = 24
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic signed [VALUE_BITS-1:0] second_value;
   logic                         end_of_stream;

   modport source (output valid, value, second_value, end_of_stream, input ready);
   modport sink   (input valid, value, second_value, end_of_stream, output ready);
endinterface

interface mwsc_rsp_if
   import mwsc_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic signed [SUM_W-1:0]  window_sum;
   logic signed [SUM_W-1:0]  second_window_sum;
   logic        [HIT_W-1:0]  hit_count;
   logic                     at_or_above;
   logic                     all_or_none;
   logic                     partial_window;

   modport source (output valid, window_sum, second_window_sum, hit_count, at_or_above,
                   all_or_none, partial_window, input ready);
   modport sink   (input valid, window_sum, second_window_sum, hit_count, at_or_above,
                   all_or_none, partial_window, output ready);
endinterface

interface mwsc_csr_if
   import mwsc_pkg::*;
;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/mwsc_ram.sv
`timescale 1ns / 1ps

module mwsc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read-first: a read and a write at one address return the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/moving_window_sum_counter_unit.sv
`timescale 1ns / 1ps

// Moving window sum unit.
// req_ch takes one request per cycle while req_ch.ready is high: a signed value, an optional second value and an
// end-of-stream mark. rsp_ch gives one result per closed window: both sums, the hit count,
// the threshold flag, the all-or-none flag and the partial-window flag. csr_ch writes the
// six configuration registers by index; any write to a known index also empties the window.
// Sliding mode gives a result for every request once window_size requests have been seen;
// tumbling mode gives one per window_size requests, plus a partial one at end of stream.
// Throughput is one request per clock while req_ch.ready is high. The accepting edge
// registers the request together with the history RAM read of the oldest entry; the
// second stage then writes the running-sum update into the result register, which
// drives rsp_ch.valid. The second stage holds the running-sum adder and consumes the
// registered history read. When rsp_ch stalls, the result register holds and the second
// stage holds behind it; req_ch.ready falls only once both are occupied, and a request
// that closes no window still drains. Reset is synchronous: it restores the register
// defaults and empties the window at once. The history RAM is not cleared; a fill count
// keeps never-written entries out of the sums, so no clearing pass is needed.
module moving_window_sum_counter_unit
   import mwsc_pkg::*;
#(
   parameter int WINDOW_MAX = 256,
   parameter int VALUE_BITS = 24
) (
   input  logic            clock,
   input  logic            reset,
   mwsc_req_if.sink        req_ch,
   mwsc_rsp_if.source      rsp_ch,
   mwsc_csr_if.sink        csr_ch
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int AW    = $clog2(WINDOW_MAX);
   localparam int DIF_W = CNT_W + 1;

   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   // Configuration registers
   logic [WSIZE_W-1:0]      win_size_ff;
   logic                    tumbling_ff;
   logic                    absval_ff;
   logic                    nonlos_ff;
   logic                    second_en_ff;
   logic signed [SUM_W-1:0] threshold_ff;

   // Window position state (first stage)
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [AW-1:0]    wp_ff, wp_in;

   // Running totals (second stage)
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic signed [SUM_W-1:0] ssum_ff, ssum_in;
   logic [CNT_W-1:0]        count_ff, count_in;

   // Second stage item
   logic                         s1_valid_ff;
   logic signed [VALUE_BITS-1:0] s1_v_ff;
   logic signed [VALUE_BITS-1:0] s1_sv_ff;
   logic                         s1_hit_ff;
   logic                         s1_sub_ff;
   logic                         s1_emit_ff;
   logic                         s1_partial_ff;
   logic                         s1_clear_ff;

   // Result register
   logic                    rsp_valid_ff;
   logic signed [SUM_W-1:0] rsp_sum_ff;
   logic signed [SUM_W-1:0] rsp_ssum_ff;
   logic [HIT_W-1:0]        rsp_hit_ff;
   logic                    rsp_above_ff;
   logic                    rsp_aon_ff;
   logic                    rsp_partial_ff;

   logic                         req_fire;
   logic                         csr_fire;
   logic                         csr_clear;
   logic [CNT_W-1:0]             eff_size;
   logic signed [VALUE_BITS-1:0] v_abs;
   logic signed [VALUE_BITS-1:0] sv_eff;
   logic                         v_hit;
   logic [CNT_W-1:0]             fill_inc;
   logic                         win_full;
   logic                         emit0;
   logic                         partial0;
   logic                         clear0;
   logic [AW-1:0]                wp_inc;
   logic [DIF_W-1:0]             old_dif;
   logic [AW-1:0]                old_addr;
   logic [2*VALUE_BITS-1:0]      rd_word;
   logic signed [VALUE_BITS-1:0] old_v;
   logic signed [VALUE_BITS-1:0] old_sv;
   logic                         old_hit;
   logic                         s1_move;
   logic signed [SUM_W-1:0]      sum_new;
   logic signed [SUM_W-1:0]      ssum_new;
   logic [CNT_W-1:0]             count_new;

   function automatic logic is_hit(input logic signed [VALUE_BITS-1:0] v, input logic nonlos);
      return nonlos ? !v[VALUE_BITS-1] : (!v[VALUE_BITS-1] && (v != '0));
   endfunction

   assign csr_ch.ready = 1'b1;
   assign csr_fire     = csr_ch.valid && csr_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;

   // Clamp the window size into 1..WINDOW_MAX
   always_comb begin
      if (win_size_ff == '0) begin
         eff_size = CNT_W'(1);
      end else if (32'(win_size_ff) > 32'(WINDOW_MAX)) begin
         eff_size = CNT_W'(WINDOW_MAX);
      end else begin
         eff_size = CNT_W'(win_size_ff);
      end
   end

   // Configuration writes; a known index also empties the window
   always_comb begin
      case (csr_ch.index)
         CSR_WINDOW_SIZE, CSR_TUMBLING_MODE, CSR_ABSOLUTE_VALUE,
         CSR_COUNT_NONLOSING, CSR_SECOND_ENABLE, CSR_SUM_THRESHOLD: csr_clear = csr_fire;
         default:                                                   csr_clear = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff  <= WINDOW_SIZE_RESET;
         tumbling_ff  <= 1'b0;
         absval_ff    <= 1'b0;
         nonlos_ff    <= 1'b0;
         second_en_ff <= 1'b0;
         threshold_ff <= '0;
      end else if (csr_fire) begin
         case (csr_ch.index)
            CSR_WINDOW_SIZE:     win_size_ff  <= csr_ch.data[WSIZE_W-1:0];
            CSR_TUMBLING_MODE:   tumbling_ff  <= csr_ch.data[0];
            CSR_ABSOLUTE_VALUE:  absval_ff    <= csr_ch.data[0];
            CSR_COUNT_NONLOSING: nonlos_ff    <= csr_ch.data[0];
            CSR_SECOND_ENABLE:   second_en_ff <= csr_ch.data[0];
            CSR_SUM_THRESHOLD:   threshold_ff <= csr_ch.data[SUM_W-1:0];
            default: ;
         endcase
      end
   end

   // First stage: condition the request and advance the window position
   always_comb begin
      v_abs = req_ch.value;
      if (absval_ff && req_ch.value[VALUE_BITS-1]) begin
         // saturate the magnitude of the most negative value
         v_abs = (req_ch.value == VAL_MIN) ? VAL_MAX : -req_ch.value;
      end
      sv_eff   = second_en_ff ? req_ch.second_value : '0;
      v_hit    = is_hit(v_abs, nonlos_ff);
      fill_inc = fill_ff + CNT_W'(1);
      win_full = (fill_ff >= eff_size);
      wp_inc   = (32'(wp_ff) == WINDOW_MAX - 1) ? '0 : wp_ff + AW'(1);

      // oldest entry sits window size places behind the write position
      old_dif  = DIF_W'(wp_ff) + DIF_W'(WINDOW_MAX) - DIF_W'(eff_size);
      if (32'(old_dif) >= 32'(WINDOW_MAX)) begin
         old_dif = old_dif - DIF_W'(WINDOW_MAX);
      end
      old_addr = old_dif[AW-1:0];

      if (tumbling_ff) begin
         emit0    = (fill_inc >= eff_size) || req_ch.end_of_stream;
         partial0 = (fill_inc < eff_size);
         clear0   = emit0;
         fill_in  = clear0 ? '0 : fill_inc;
         wp_in    = '0;
      end else begin
         emit0    = win_full || (fill_inc >= eff_size);
         partial0 = 1'b0;
         clear0   = req_ch.end_of_stream;
         fill_in  = clear0 ? '0 : (win_full ? fill_ff : fill_inc);
         wp_in    = clear0 ? '0 : wp_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_clear) begin
         fill_ff <= '0;
         wp_ff   <= '0;
      end else if (req_fire) begin
         fill_ff <= fill_in;
         wp_ff   <= wp_in;
      end
   end

   // Value and second value histories share one word
   mwsc_ram #(
      .WIDTH (2 * VALUE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_hist (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (wp_ff),
      .wr_data ({sv_eff, v_abs}),
      .rd_en   (req_fire),
      .rd_addr (old_addr),
      .rd_data (rd_word)
   );

   // Second stage: advance when the item emits no result or the result has somewhere to go
   assign s1_move      = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_v_ff       <= v_abs;
         s1_sv_ff      <= sv_eff;
         s1_hit_ff     <= v_hit;
         s1_sub_ff     <= !tumbling_ff && win_full;
         s1_emit_ff    <= emit0;
         s1_partial_ff <= partial0;
         s1_clear_ff   <= clear0;
      end
   end

   // Add the new value and drop the oldest one when a sliding window is full; a clearing item zeroes the stored totals
   always_comb begin
      old_v     = rd_word[VALUE_BITS-1:0];
      old_sv    = rd_word[2*VALUE_BITS-1:VALUE_BITS];
      old_hit   = s1_sub_ff && is_hit(old_v, nonlos_ff);
      sum_new   = sum_ff + SUM_W'(s1_v_ff) - (s1_sub_ff ? SUM_W'(old_v) : '0);
      ssum_new  = ssum_ff + SUM_W'(s1_sv_ff) - (s1_sub_ff ? SUM_W'(old_sv) : '0);
      count_new = count_ff + CNT_W'(s1_hit_ff) - CNT_W'(old_hit);
      sum_in    = s1_clear_ff ? '0 : sum_new;
      ssum_in   = s1_clear_ff ? '0 : ssum_new;
      count_in  = s1_clear_ff ? '0 : count_new;
   end

   always_ff @(posedge clock) begin
      if (reset || csr_clear) begin
         sum_ff   <= '0;
         ssum_ff  <= '0;
         count_ff <= '0;
      end else if (s1_move) begin
         sum_ff   <= sum_in;
         ssum_ff  <= ssum_in;
         count_ff <= count_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && s1_emit_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_emit_ff) begin
         rsp_sum_ff     <= sum_new;
         rsp_ssum_ff    <= second_en_ff ? ssum_new : '0;
         rsp_hit_ff     <= HIT_W'(count_new);
         rsp_above_ff   <= (sum_new >= threshold_ff);
         rsp_aon_ff     <= (count_new == '0) || (count_new == eff_size);
         rsp_partial_ff <= s1_partial_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.window_sum        = rsp_sum_ff;
   assign rsp_ch.second_window_sum = rsp_ssum_ff;
   assign rsp_ch.hit_count         = rsp_hit_ff;
   assign rsp_ch.at_or_above       = rsp_above_ff;
   assign rsp_ch.all_or_none       = rsp_aon_ff;
   assign rsp_ch.partial_window    = rsp_partial_ff;

endmodule

// File: rtl/mwsc_checker.sv
`timescale 1ns / 1ps

module mwsc_checker
   import mwsc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [SUM_W-1:0] rsp_window_sum,
   input logic [HIT_W-1:0] rsp_hit_count,
   input logic             rsp_all_or_none
);

   // A stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its sum
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=> $stable(rsp_window_sum))
      else $error("result sum changed while stalled");

   // Reset empties the result register
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // A window with no hits is all-or-none
   a_no_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_hit_count == '0) |-> rsp_all_or_none)
      else $error("empty hit count not flagged");

endmodule

bind moving_window_sum_counter_unit mwsc_checker u_mwsc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_window_sum  (rsp_ch.window_sum),
   .rsp_hit_count   (rsp_ch.hit_count),
   .rsp_all_or_none (rsp_ch.all_or_none)
);
